[rtl/assert_macros.svh]
// assertion helpers for the rtl, included by dcrr_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/dcrr_pkg.sv]
// ----------------------------------------------------------------------------
// dcrr_pkg
// shared types and constants of the dma channel result register block
// ----------------------------------------------------------------------------
package dcrr_pkg;

  localparam int unsigned CHANNELS   = 16;
  localparam int unsigned FIFO_DEPTH = 7;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned PTR_W      = 3;

  typedef logic [CHANNELS-1:0] ch_mask_t;

  // beat kinds
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_LINE   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_ACCESS    = 3'd1,
    ERR_FLUSHTYPE = 3'd2,
    ERR_NOFORCE   = 3'd3,
    ERR_OVERFLOW  = 3'd4,
    ERR_BUSY      = 3'd5,
    ERR_LINE      = 3'd6
  } err_t;

  // register offsets with channel bits cleared
  localparam logic [12:0] REG_CMD    = 13'h000;
  localparam logic [12:0] REG_RSLT   = 13'h040;
  localparam logic [12:0] REG_FLUSH  = 13'h080;
  localparam logic [12:0] REG_STATUS = 13'h200;
  localparam logic [12:0] REG_CONF   = 13'h300;
  localparam logic [12:0] REG_ISR    = 13'h380;
  localparam logic [12:0] CHAN_BITS  = 13'h03C;

  localparam int unsigned RES_VALID_BIT  = 31;
  localparam int unsigned RES_FLUSH_BIT  = 2;
  localparam int unsigned RES_DONE_BIT   = 1;
  localparam int unsigned STAT_COUNT_LSB = 29;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture input beat
    logic exec;   // apply the beat to channel state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;   // result register filled
  } dp_stat_t;

endpackage

[rtl/dcrr_ctrl.sv]
// ----------------------------------------------------------------------------
// dcrr_ctrl
// sequencer: take a beat, run it through the datapath, hold the result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output dcrr_pkg::dp_cmd_t cmd,
  input  dcrr_pkg::dp_stat_t stat
);

  dcrr_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcrr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      dcrr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = dcrr_pkg::ST_EXEC;
        end
      end
      dcrr_pkg::ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = dcrr_pkg::ST_OUT;
      end
      dcrr_pkg::ST_OUT: begin
        out_valid = 1'b1;
        // take the next beat while the result is taken
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = dcrr_pkg::ST_EXEC;
          end else begin
            state_nxt = dcrr_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = dcrr_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_exec_fills, cmd.exec, stat.done && out_valid, "result not ready after exec")
  `ASSERT_NEXT(a_load_exec, cmd.load, cmd.exec, "load not followed by exec")
  `ASSERT_CLK(a_no_both, !(cmd.load && cmd.exec), "load and exec together")

endmodule

[rtl/dcrr_dp.sv]
// ----------------------------------------------------------------------------
// dcrr_dp
// channel state, result fifos and register decode
// ----------------------------------------------------------------------------
module dcrr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  dcrr_pkg::dp_cmd_t  cmd,
  output dcrr_pkg::dp_stat_t stat,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic [1:0]         in_kind,
  input  logic [12:0]        in_offset,
  input  logic [31:0]        in_write_data,
  input  logic [3:0]         in_first_line,
  input  logic               in_line_high,
  input  logic [3:0]         in_asserted_line,
  output logic [31:0]        out_read_data,
  output logic [2:0]         out_error,
  output logic               out_irq,
  output logic [15:0]        out_completed_mask
);

  localparam int unsigned N = dcrr_pkg::CHANNELS;
  localparam int unsigned D = dcrr_pkg::FIFO_DEPTH;
  localparam int unsigned PW = dcrr_pkg::PTR_W;

  logic [15:0] crci_r;
  logic [1:0]  kind_r;
  logic [12:0] off_r;
  logic [31:0] data_r;
  logic [3:0]  first_r, asrt_r;
  logic        high_r;

  logic [1:0]    conf_r  [N];
  logic [D-1:0]  fifo_r  [N];
  logic [PW-1:0] head_r  [N];
  logic [PW-1:0] cnt_r   [N];
  logic          busy_r  [N];
  logic [3:0]    paced_r [N];
  logic [3:0]    await_r [N];
  logic          done_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) crci_r <= '0;
    else if (cfg_we) crci_r <= cfg_wdata;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      off_r  <= in_offset;
      data_r <= in_write_data;
      first_r <= in_first_line;
      high_r <= in_line_high;
      asrt_r <= in_asserted_line;
    end
  end

  // decode
  logic [12:0]         reg_off;
  logic [dcrr_pkg::CH_W-1:0] ch;
  logic                known, ch_ok;
  assign reg_off = off_r & ~dcrr_pkg::CHAN_BITS;
  assign ch      = off_r[5:2];
  assign ch_ok   = ({1'b0, ch} < 5'(N));
  assign known   = (reg_off == dcrr_pkg::REG_CMD) || (reg_off == dcrr_pkg::REG_RSLT) ||
                   (reg_off == dcrr_pkg::REG_FLUSH) || (reg_off == dcrr_pkg::REG_STATUS) ||
                   (reg_off == dcrr_pkg::REG_CONF);

  // wrap a fifo pointer sum
  function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
    logic [PW:0] t;
    t = (v >= (PW+1)'(D)) ? v - (PW+1)'(D) : v;
    return t[PW-1:0];
  endfunction

  // next state of all channels and the result
  logic [1:0]    conf_n  [N];
  logic [D-1:0]  fifo_n  [N];
  logic [PW-1:0] head_n  [N];
  logic [PW-1:0] cnt_n   [N];
  logic          busy_n  [N];
  logic [3:0]    paced_n [N];
  logic [3:0]    await_n [N];
  logic [31:0]   rd;
  logic [2:0]    err;
  logic [15:0]   done_m;
  logic [15:0]   isr_now;
  logic [PW-1:0] slot;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      conf_n[i] = conf_r[i]; fifo_n[i] = fifo_r[i]; head_n[i] = head_r[i];
      cnt_n[i] = cnt_r[i]; busy_n[i] = busy_r[i]; paced_n[i] = paced_r[i];
      await_n[i] = await_r[i];
    end
    isr_now = '0;
    for (int i = 0; i < N; i++) isr_now[i] = (cnt_r[i] != '0) && conf_r[i][0];
    rd = '0; err = dcrr_pkg::ERR_OK; done_m = '0;
    slot = wrap({1'b0, head_r[ch]} + {1'b0, cnt_r[ch]});
    unique case (dcrr_pkg::kind_t'(kind_r))
      dcrr_pkg::KIND_READ, dcrr_pkg::KIND_WRITE: begin
        priority if (kind_r == dcrr_pkg::KIND_READ && off_r == dcrr_pkg::REG_ISR) begin
          rd = 32'(isr_now);
        end else if (off_r[1:0] != 2'b00 || !known || !ch_ok) begin
          err = dcrr_pkg::ERR_ACCESS;
        end else if (kind_r == dcrr_pkg::KIND_READ) begin
          priority if (reg_off == dcrr_pkg::REG_STATUS) begin
            rd = 32'd1;
            if (cnt_r[ch] != '0) begin
              rd[dcrr_pkg::RES_DONE_BIT] = 1'b1;
              rd[31:dcrr_pkg::STAT_COUNT_LSB] = cnt_r[ch];
            end
          end else if (reg_off == dcrr_pkg::REG_RSLT) begin
            if (cnt_r[ch] != '0) begin
              rd[dcrr_pkg::RES_VALID_BIT] = 1'b1;
              if (fifo_r[ch][head_r[ch]]) rd[dcrr_pkg::RES_FLUSH_BIT] = 1'b1;
              else rd[dcrr_pkg::RES_DONE_BIT] = 1'b1;
              head_n[ch] = wrap({1'b0, head_r[ch]} + (PW+1)'(1));
              cnt_n[ch]  = cnt_r[ch] - PW'(1);
            end
          end else if (reg_off == dcrr_pkg::REG_CONF) begin
            rd = 32'(conf_r[ch]);
          end else begin
            err = dcrr_pkg::ERR_ACCESS;
          end
        end else if (reg_off == dcrr_pkg::REG_CONF) begin
          if (data_r[31:2] != '0) err = dcrr_pkg::ERR_ACCESS;
          else conf_n[ch] = data_r[1:0];
        end else if (reg_off == dcrr_pkg::REG_FLUSH) begin
          if (data_r != '0) err = dcrr_pkg::ERR_FLUSHTYPE;
          else if (busy_r[ch]) begin
            if (!conf_r[ch][1]) err = dcrr_pkg::ERR_NOFORCE;
            else if (cnt_r[ch] >= PW'(D)) err = dcrr_pkg::ERR_OVERFLOW;
            else begin
              busy_n[ch] = 1'b0; paced_n[ch] = '0; await_n[ch] = '0;
              fifo_n[ch][slot] = 1'b1;
              cnt_n[ch] = cnt_r[ch] + PW'(1);
            end
          end
        end else if (reg_off == dcrr_pkg::REG_CMD) begin
          if (busy_r[ch]) err = dcrr_pkg::ERR_BUSY;
          else if (first_r != '0 && !crci_r[first_r]) err = dcrr_pkg::ERR_LINE;
          else begin
            busy_n[ch]  = 1'b1;
            paced_n[ch] = first_r;
            await_n[ch] = (first_r != '0 && !high_r) ? first_r : 4'd0;
          end
        end else begin
          err = dcrr_pkg::ERR_ACCESS;
        end
      end
      dcrr_pkg::KIND_LINE: begin
        for (int i = 0; i < N; i++)
          if (busy_r[i] && await_r[i] == asrt_r) await_n[i] = '0;
      end
      dcrr_pkg::KIND_TICK: begin
        for (int i = 0; i < N; i++) begin
          if (busy_r[i] && await_r[i] == '0) begin
            if (cnt_r[i] >= PW'(D)) err = dcrr_pkg::ERR_OVERFLOW;
            else begin
              fifo_n[i][wrap({1'b0, head_r[i]} + {1'b0, cnt_r[i]})] = 1'b0;
              cnt_n[i] = cnt_r[i] + PW'(1);
            end
            busy_n[i] = 1'b0; paced_n[i] = '0; await_n[i] = '0;
            done_m[i] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (err != dcrr_pkg::ERR_OK) rd = '0;
  end

  // irq from the next state
  logic irq_n;
  always_comb begin
    irq_n = 1'b0;
    for (int i = 0; i < N; i++) irq_n |= (cnt_n[i] != '0) && conf_n[i][0];
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        conf_r[i] <= '0; head_r[i] <= '0; cnt_r[i] <= '0;
        busy_r[i] <= 1'b0; paced_r[i] <= '0; await_r[i] <= '0;
      end
      done_r <= 1'b0;
    end else begin
      done_r <= cmd.exec;
      if (cmd.exec) begin
        for (int i = 0; i < N; i++) begin
          conf_r[i] <= conf_n[i]; head_r[i] <= head_n[i]; cnt_r[i] <= cnt_n[i];
          busy_r[i] <= busy_n[i]; paced_r[i] <= paced_n[i]; await_r[i] <= await_n[i];
        end
      end
    end
  end

  // fifo contents and result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < N; i++) fifo_r[i] <= fifo_n[i];
      out_read_data      <= rd;
      out_error          <= err;
      out_irq            <= irq_n;
      out_completed_mask <= done_m;
    end
  end

  assign stat.done = done_r;

endmodule

[rtl/dma_channel_result_registers.sv]
// ----------------------------------------------------------------------------
// dma_channel_result_registers
// register face of a sixteen-channel dma mover with per-channel result fifos
// ----------------------------------------------------------------------------
//  channel | signals                                         | dir
//  in      | in_valid/in_ready, kind offset data lines       | in
//  out     | out_valid/out_ready, read_data error irq mask   | out
//  cfg     | cfg_we, cfg_wdata (declared pacing lines)       | in
//
// a beat is captured, then makes one pass of the channel update logic
// a new beat is taken in the same cycle the previous result leaves
// out_ready low holds the result and blocks further beats
// synchronous active-low reset clears the config mask and all channel state except the fifo bits
module dma_channel_result_registers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [12:0] in_offset,
  input  logic [31:0] in_write_data,
  input  logic [3:0]  in_first_line,
  input  logic        in_line_high,
  input  logic [3:0]  in_asserted_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic [2:0]  out_error,
  output logic        out_irq,
  output logic [15:0] out_completed_mask
);

  dcrr_pkg::dp_cmd_t  cmd;
  dcrr_pkg::dp_stat_t stat;

  dcrr_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  dcrr_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_wdata,
    .in_kind, .in_offset, .in_write_data, .in_first_line, .in_line_high,
    .in_asserted_line, .out_read_data, .out_error, .out_irq, .out_completed_mask
  );

endmodule
